[hdl/fibonacci_mod_matrix_power_defines.svh]
// assertion macros shared by the fibonacci matrix power rtl
`ifndef FIBONACCI_MOD_MATRIX_POWER_DEFINES_SVH
`define FIBONACCI_MOD_MATRIX_POWER_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define FMMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define FMMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fmmp_pkg.sv]
// constants and types for the fibonacci matrix power block
`timescale 1ns / 1ps

package fmmp_pkg;

  localparam int INDEX_BITS = 63;
  localparam int VAL_W      = 30;

  localparam logic [VAL_W-1:0] FIB_MOD    = 30'd1000000007;
  localparam logic [31:0]      FIB_MOD_1X = 32'd1000000007;
  localparam logic [31:0]      FIB_MOD_2X = 32'd2000000014;
  localparam logic [31:0]      FIB_MOD_3X = 32'd3000000021;
  // floor(2^60 / modulus)
  localparam logic [30:0]      BARRETT_MU = 31'd1152921496;

  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    logic valid;
    val_t a;
    val_t b;
  } mm_req_t;

  typedef struct packed {
    logic valid;
    val_t value;
  } mm_rsp_t;

endpackage

[hdl/fmmp_modmul.sv]
// pipelined modular multiplier with barrett reduction, one product per cycle
`timescale 1ns / 1ps
`include "fibonacci_mod_matrix_power_defines.svh"

module fmmp_modmul
  import fmmp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req_i,
  output mm_rsp_t rsp_o
);

  logic        va_r, vb_r, vc_r, vd_r, ve_r;
  logic [59:0] x_r;
  logic [61:0] q2_r;
  logic [31:0] xlo_b_r, xlo_c_r;
  logic [31:0] qp_lo_r;
  logic [31:0] r_r;
  val_t        res_r;

  logic [29:0] q3;
  logic [59:0] qp_full;
  val_t        res_nxt;

  assign q3      = q2_r[60:31];
  assign qp_full = 60'(q3) * 60'(FIB_MOD);

  always_comb begin
    if (r_r >= FIB_MOD_2X) begin
      res_nxt = VAL_W'(r_r - FIB_MOD_2X);
    end else if (r_r >= FIB_MOD_1X) begin
      res_nxt = VAL_W'(r_r - FIB_MOD_1X);
    end else begin
      res_nxt = VAL_W'(r_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      va_r <= req_i.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= 60'(req_i.a) * 60'(req_i.b);
    q2_r    <= 62'(x_r[59:29]) * 62'(BARRETT_MU);
    xlo_b_r <= x_r[31:0];
    qp_lo_r <= qp_full[31:0];
    xlo_c_r <= xlo_b_r;
    r_r     <= xlo_c_r - qp_lo_r;
    res_r   <= res_nxt;
  end

  assign rsp_o.valid = ve_r;
  assign rsp_o.value = res_r;

  `FMMP_ASSERT_IMP(a_prod_bound, va_r, x_r < 60'(FIB_MOD) * 60'(FIB_MOD), "product too large")
  `FMMP_ASSERT_IMP(a_rem_bound, vd_r, r_r < FIB_MOD_3X, "barrett remainder out of range")
  `FMMP_ASSERT_NXT(a_out_reduced, vd_r, rsp_o.value < FIB_MOD, "result not reduced")

endmodule

[hdl/fibonacci_mod_matrix_power.sv]
// fibonacci number modulo 1000000007 by 2x2 matrix power
//
// input channel: in_valid, in_index, in_stall; an item is taken when in_valid
// is high and in_stall is low. in_stall is high while an item is in work.
// result channel: out_valid, out_fib_value, out_stall; one result per item,
// held in an output register until out_stall is low.
// the exponent n-2 is walked lsb first; each set bit costs a matrix product
// into the accumulator and each bit but the top one a squaring of the base.
// every matrix product issues its 8 multiplies into one pipelined modular
// multiplier, then does the 4 modular adds; for n below 3 the exponent is 0
// and no matrix product is done.
// a new item is taken as soon as the previous one finishes, even while its
// result still waits; the block then holds until that result is taken.
// reset is synchronous, active low, and empties the block and the output.
`timescale 1ns / 1ps
`include "fibonacci_mod_matrix_power_defines.svh"

module fibonacci_mod_matrix_power
  import fmmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [INDEX_BITS-1:0] in_index,
  output logic                  in_stall,
  output logic                  out_valid,
  output logic [VAL_W-1:0]      out_fib_value,
  input  logic                  out_stall
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [INDEX_BITS-1:0] exp_r, exp_nxt;
  logic                  op_sq_r, op_sq_nxt;
  logic [3:0]            iss_cnt_r, iss_cnt_nxt;
  logic [3:0]            col_cnt_r, col_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  val_t                  out_value_r, out_value_nxt;
  val_t                  acc_r [4];
  val_t                  acc_nxt [4];
  val_t                  base_r [4];
  val_t                  base_nxt [4];
  val_t                  prod_r [8];

  val_t                  xm [4];
  val_t                  sum_red [4];
  logic [VAL_W:0]        sum_raw [4];
  logic [VAL_W:0]        fin_raw;
  val_t                  fin_red;
  mm_req_t               mm_req;
  mm_rsp_t               mm_rsp;

  fmmp_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (mm_req),
    .rsp_o (mm_rsp)
  );

  // left operand is the accumulator or, when squaring, the base
  always_comb begin
    for (int e = 0; e < 4; e++) begin
      xm[e] = op_sq_r ? base_r[e] : acc_r[e];
    end
  end

  always_comb begin
    mm_req.valid = (state_r == S_MUL) && !iss_cnt_r[3];
    case (iss_cnt_r[2:0])
      3'd0: begin mm_req.a = xm[0]; mm_req.b = base_r[0]; end
      3'd1: begin mm_req.a = xm[1]; mm_req.b = base_r[2]; end
      3'd2: begin mm_req.a = xm[0]; mm_req.b = base_r[1]; end
      3'd3: begin mm_req.a = xm[1]; mm_req.b = base_r[3]; end
      3'd4: begin mm_req.a = xm[2]; mm_req.b = base_r[0]; end
      3'd5: begin mm_req.a = xm[3]; mm_req.b = base_r[2]; end
      3'd6: begin mm_req.a = xm[2]; mm_req.b = base_r[1]; end
      3'd7: begin mm_req.a = xm[3]; mm_req.b = base_r[3]; end
      default: begin mm_req.a = xm[0]; mm_req.b = base_r[0]; end
    endcase
  end

  // entry e of the product is the sum of the two partial products 2e and 2e+1
  always_comb begin
    for (int e = 0; e < 4; e++) begin
      sum_raw[e] = {1'b0, prod_r[2*e]} + {1'b0, prod_r[2*e+1]};
      if (sum_raw[e] >= {1'b0, FIB_MOD}) begin
        sum_red[e] = VAL_W'(sum_raw[e] - {1'b0, FIB_MOD});
      end else begin
        sum_red[e] = VAL_W'(sum_raw[e]);
      end
    end
  end

  assign fin_raw = {1'b0, acc_r[1]} + {1'b0, acc_r[3]};
  assign fin_red = (fin_raw >= {1'b0, FIB_MOD}) ? VAL_W'(fin_raw - {1'b0, FIB_MOD})
                                                : VAL_W'(fin_raw);

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    op_sq_nxt     = op_sq_r;
    iss_cnt_nxt   = iss_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    for (int e = 0; e < 4; e++) begin
      acc_nxt[e]  = acc_r[e];
      base_nxt[e] = base_r[e];
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_index < INDEX_BITS'(3)) begin
            exp_nxt = '0;
          end else begin
            exp_nxt = in_index - INDEX_BITS'(2);
          end
          // zero matrix yields 0 for index zero, identity yields 1
          acc_nxt[0]  = (in_index != '0) ? VAL_W'(1) : '0;
          acc_nxt[1]  = '0;
          acc_nxt[2]  = '0;
          acc_nxt[3]  = (in_index != '0) ? VAL_W'(1) : '0;
          base_nxt[0] = '0;
          base_nxt[1] = VAL_W'(1);
          base_nxt[2] = VAL_W'(1);
          base_nxt[3] = VAL_W'(1);
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        iss_cnt_nxt = '0;
        col_cnt_nxt = '0;
        if (exp_r == '0) begin
          state_nxt = S_FINAL;
        end else begin
          op_sq_nxt = !exp_r[0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mm_req.valid) begin
          iss_cnt_nxt = iss_cnt_r + 4'd1;
        end
        if (mm_rsp.valid) begin
          col_cnt_nxt = col_cnt_r + 4'd1;
          if (col_cnt_r == 4'd7) begin
            state_nxt = S_ADD;
          end
        end
      end
      S_ADD: begin
        for (int e = 0; e < 4; e++) begin
          if (op_sq_r) begin
            base_nxt[e] = sum_red[e];
          end else begin
            acc_nxt[e] = sum_red[e];
          end
        end
        if (op_sq_r) begin
          exp_nxt = exp_r >> 1;
        end else begin
          exp_nxt = {exp_r[INDEX_BITS-1:1], 1'b0};
        end
        state_nxt = S_CHECK;
      end
      S_FINAL: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = fin_red;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_sq_r     <= 1'b0;
      iss_cnt_r   <= '0;
      col_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_sq_r     <= op_sq_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exp_r       <= exp_nxt;
    out_value_r <= out_value_nxt;
    for (int e = 0; e < 4; e++) begin
      acc_r[e]  <= acc_nxt[e];
      base_r[e] <= base_nxt[e];
    end
    if (mm_rsp.valid) begin
      prod_r[col_cnt_r[2:0]] <= mm_rsp.value;
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_fib_value = out_value_r;

  `FMMP_ASSERT_IMP(a_accept_idle, in_valid && !in_stall, state_r == S_IDLE, "item taken while busy")
  `FMMP_ASSERT_IMP(a_col_le_iss, state_r == S_MUL, col_cnt_r <= iss_cnt_r, "more results than issues")
  `FMMP_ASSERT_IMP(a_rsp_in_mul, mm_rsp.valid, state_r == S_MUL, "stray multiplier result")
  `FMMP_ASSERT_IMP(a_final_exp, state_r == S_FINAL, exp_r == '0, "exponent left at finish")
  `FMMP_ASSERT_IMP(a_out_reduced, out_valid, out_fib_value < FIB_MOD, "result not reduced")

endmodule
